FILE: src/emp_pkg.sv
// Shared types and constants for the event message priority display.
// Holds the tick and display transaction layouts, message and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package emp_pkg;

  localparam int unsigned NUM_PAGES = 5;
  localparam logic [2:0]  PAGE_LAST = 3'(NUM_PAGES - 1);

  localparam logic [15:0] EVENT_HOLD_RST  = 16'd1000;
  localparam logic [15:0] BLANK_RST       = 16'd500;
  localparam logic [15:0] FAULT_MASK_RST  = 16'hFFFF;
  localparam logic [2:0]  PAGE_RST        = 3'd0;
  localparam logic [2:0]  EVENTS_PAGE_RST = 3'd0;
  localparam logic        ACK_ENABLE_RST  = 1'b1;

  typedef enum logic [2:0] {
    CFG_EVENT_HOLD   = 3'd0,
    CFG_BLANK        = 3'd1,
    CFG_FAULT_MASK   = 3'd2,
    CFG_DEFAULT_PAGE = 3'd3,
    CFG_EVENTS_PAGE  = 3'd4,
    CFG_ACK_ENABLE   = 3'd5
  } cfg_index_t;

  typedef enum logic [3:0] {
    CODE_NONE     = 4'd0,
    CODE_BRAKE    = 4'd1,
    CODE_ACK      = 4'd2,
    CODE_FAULT    = 4'd3,
    CODE_MAIN     = 4'd4,
    CODE_PARK     = 4'd5,
    CODE_LEFT     = 4'd6,
    CODE_RIGHT    = 4'd7,
    CODE_HAZARD   = 4'd8,
    CODE_REMINDER = 4'd9
  } msg_code_t;

  typedef enum logic [1:0] {
    TURN_OFF    = 2'd0,
    TURN_LEFT   = 2'd1,
    TURN_RIGHT  = 2'd2,
    TURN_HAZARD = 2'd3
  } turn_mode_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        page_button_rose;
    logic [3:0]  point_number;
    logic        braking;
    logic        main_light_on;
    logic        park_light_on;
    logic [15:0] fault_bits;
    logic        ack_rose;
    logic [1:0]  turn_mode;
    logic        reminder_active;
  } tick_t;

  typedef struct packed {
    logic [2:0] page_index;
    logic       blanked;
    logic [3:0] message_code;
    logic [3:0] point_digit;
  } disp_t;

endpackage

`default_nettype wire

FILE: src/emp_tick_if.sv
// Input channel carrying one scan tick per transaction.
// Depends on emp_pkg for the tick layout.
`timescale 1ns / 1ps
`default_nettype none

interface emp_tick_if;
  logic            valid;
  logic            ready;
  emp_pkg::tick_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/emp_disp_if.sv
// Output channel carrying one display state per transaction.
// Depends on emp_pkg for the display layout.
`timescale 1ns / 1ps
`default_nettype none

interface emp_disp_if;
  logic            valid;
  logic            ready;
  emp_pkg::disp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/emp_cfg_if.sv
// Register write channel: index and write data per transaction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface emp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: src/event_message_priority_display.sv
// Event message priority display: page select, point-change blanking, event hold timers.
// Depends on emp_pkg, emp_tick_if, emp_disp_if and emp_cfg_if.
//
// Usage:
//   tick carries one scan tick per transaction (timestamp plus vehicle signals).
//   disp returns exactly one display state per accepted tick, in order.
//   cfg writes the registers; it is always ready and takes a write per cycle.
//   Write registers only while no tick is in flight.
// Timing:
//   A tick is latched into the input register, evaluated combinationally against
//   the page, blanking and timer state, and lands in the result register.
//   disp.valid rises when the tick moves from the input to the result register.
//   Throughput is one tick per cycle unless disp stalls (single evaluation stage).
//   When disp stalls, the result register holds, the input register keeps one
//   further tick, and tick.ready drops until the result is taken.
// Reset:
//   rst clears both stages, all timers and edge history, returns the page to
//   page 0 and the registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none

module event_message_priority_display (
  input  wire logic   clk,
  input  wire logic   rst,
  emp_tick_if.sink    tick,
  emp_disp_if.source  disp,
  emp_cfg_if.sink     cfg
);
  import emp_pkg::*;

  localparam int unsigned NUM_PULSES = 5;
  localparam int unsigned P_BRAKE = 0;
  localparam int unsigned P_ACK   = 1;
  localparam int unsigned P_FAULT = 2;
  localparam int unsigned P_MAIN  = 3;
  localparam int unsigned P_PARK  = 4;

  localparam msg_code_t PULSE_MSG [NUM_PULSES] =
    '{CODE_BRAKE, CODE_ACK, CODE_FAULT, CODE_MAIN, CODE_PARK};

  // Registers
  logic [15:0] event_hold_ms;
  logic [15:0] blank_ms;
  logic [15:0] fault_mask;
  logic [2:0]  events_page;
  logic        ack_enable;

  // Pipeline
  logic  stg_valid;
  tick_t stg;
  logic  advance;

  // Block state
  logic [2:0]  page_reg;
  logic [3:0]  point_reg;
  logic        blank_flag;
  logic [31:0] blank_start;
  logic [NUM_PULSES-1:0] pulse_active;
  logic [31:0] pulse_start [NUM_PULSES];
  logic [2:0]  prev_levels;

  logic [2:0]  page_next;
  logic        blank_flag_next;
  logic [31:0] blank_start_next;
  logic [NUM_PULSES-1:0] pulse_active_next;
  logic [31:0] pulse_start_next [NUM_PULSES];
  logic [2:0]  prev_levels_next;
  logic [31:0] blank_elapsed;
  logic [31:0] pulse_elapsed [NUM_PULSES];
  logic        point_change;
  logic        blanked;
  logic        events_on;
  logic        found;
  logic [NUM_PULSES-1:0] fire;
  logic [NUM_PULSES-1:0] act_eff;
  logic [NUM_PULSES-1:0] live;
  msg_code_t   msg;

  assign cfg.ready  = 1'b1;
  assign advance    = stg_valid && (!disp.valid || disp.ready);
  assign tick.ready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_hold_ms <= EVENT_HOLD_RST;
      blank_ms      <= BLANK_RST;
      fault_mask    <= FAULT_MASK_RST;
      events_page   <= EVENTS_PAGE_RST;
      ack_enable    <= ACK_ENABLE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_EVENT_HOLD:   event_hold_ms <= cfg.wdata;
        CFG_BLANK:        blank_ms      <= cfg.wdata;
        CFG_FAULT_MASK:   fault_mask    <= cfg.wdata;
        CFG_DEFAULT_PAGE: ; // page reset value is fixed
        CFG_EVENTS_PAGE:  events_page   <= cfg.wdata[2:0];
        CFG_ACK_ENABLE:   ack_enable    <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    page_next = page_reg;
    if (stg.page_button_rose) begin
      page_next = (page_reg == PAGE_LAST) ? 3'd0 : page_reg + 3'd1;
    end

    point_change     = stg.point_number != point_reg;
    blank_start_next = point_change ? stg.now_ms : blank_start;
    blank_elapsed    = stg.now_ms - blank_start_next;
    blanked          = (point_change || blank_flag) &&
                       (blank_elapsed < {16'd0, blank_ms});
    blank_flag_next  = blanked;

    events_on = !blanked && (page_next == events_page);

    fire[P_BRAKE] = stg.braking && !prev_levels[0];
    fire[P_ACK]   = ack_enable && stg.ack_rose;
    fire[P_FAULT] = |(stg.fault_bits & fault_mask);
    fire[P_MAIN]  = stg.main_light_on && !prev_levels[1];
    fire[P_PARK]  = stg.park_light_on && !prev_levels[2];

    act_eff = pulse_active | fire;
    for (int k = 0; k < NUM_PULSES; k++) begin
      pulse_start_next[k] = fire[k] ? stg.now_ms : pulse_start[k];
      pulse_elapsed[k]    = stg.now_ms - pulse_start_next[k];
      live[k]             = act_eff[k] && (pulse_elapsed[k] < {16'd0, event_hold_ms});
    end

    // Walk in priority order; stop expiring at the first live timer
    found             = 1'b0;
    msg               = CODE_NONE;
    pulse_active_next = act_eff;
    for (int k = 0; k < NUM_PULSES; k++) begin
      if (!found) begin
        pulse_active_next[k] = live[k];
        if (live[k]) begin
          found = 1'b1;
          msg   = PULSE_MSG[k];
        end
      end
    end

    if (!found) begin
      unique case (stg.turn_mode)
        TURN_HAZARD: msg = CODE_HAZARD;
        TURN_LEFT:   msg = stg.reminder_active ? CODE_REMINDER : CODE_LEFT;
        TURN_RIGHT:  msg = stg.reminder_active ? CODE_REMINDER : CODE_RIGHT;
        TURN_OFF:    msg = CODE_NONE;
      endcase
    end

    prev_levels_next = {stg.park_light_on, stg.main_light_on, stg.braking};

    if (!events_on) begin
      msg               = CODE_NONE;
      pulse_active_next = pulse_active;
      prev_levels_next  = prev_levels;
      for (int k = 0; k < NUM_PULSES; k++) begin
        pulse_start_next[k] = pulse_start[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (tick.ready) begin
      stg_valid <= tick.valid;
    end
    if (tick.valid && tick.ready) begin
      stg <= tick.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_reg     <= PAGE_RST;
      point_reg    <= 4'd0;
      blank_flag   <= 1'b0;
      pulse_active <= '0;
      prev_levels  <= 3'd0;
    end else if (advance) begin
      page_reg     <= page_next;
      point_reg    <= stg.point_number;
      blank_flag   <= blank_flag_next;
      pulse_active <= pulse_active_next;
      prev_levels  <= prev_levels_next;
    end
    if (advance) begin
      blank_start <= blank_start_next;
      for (int k = 0; k < NUM_PULSES; k++) begin
        pulse_start[k] <= pulse_start_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disp.valid <= 1'b0;
    end else if (advance) begin
      disp.valid <= 1'b1;
    end else if (disp.ready) begin
      disp.valid <= 1'b0;
    end
    if (advance) begin
      disp.data.page_index   <= page_next;
      disp.data.blanked      <= blanked;
      disp.data.message_code <= msg;
      disp.data.point_digit  <= stg.point_number;
    end
  end

  a_blank_quiet: assert property (@(posedge clk) disable iff (rst)
    disp.valid && disp.data.blanked |-> disp.data.message_code == CODE_NONE)
    else $error("message shown while blanked");

  a_msg_on_events_page: assert property (@(posedge clk) disable iff (rst)
    disp.valid && disp.data.message_code != CODE_NONE |->
    disp.data.page_index == events_page)
    else $error("message shown outside the events page");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stg_valid && !advance |=> stg_valid && $stable(stg))
    else $error("pending tick lost while result stalled");

  a_page_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, page_reg} < 4'(NUM_PAGES))
    else $error("page register out of range");

endmodule

`default_nettype wire

FILE: tb/tb_event_message_priority_display.sv
// Self-checking testbench for event_message_priority_display.
// Drives scan ticks and register writes, predicts every display transaction and
// compares it field by field. Depends on emp_pkg and the emp_*_if interfaces.
`timescale 1ns / 1ps

module tb_event_message_priority_display;
  import emp_pkg::*;

  typedef enum int {EV_BRAKE, EV_ACK, EV_FAULT, EV_MAIN, EV_PARK} hold_slot_t;

  logic clk = 1'b0;
  logic rst;

  emp_tick_if tick ();
  emp_disp_if disp ();
  emp_cfg_if  cfg ();

  event_message_priority_display u_top (
    .clk  (clk),
    .rst  (rst),
    .tick (tick.sink),
    .disp (disp.source),
    .cfg  (cfg.sink)
  );

  always #2 clk = ~clk;

  // register copies
  logic [15:0] cfg_hold         = EVENT_HOLD_RST;
  logic [15:0] cfg_blank        = BLANK_RST;
  logic [15:0] cfg_mask         = FAULT_MASK_RST;
  logic [2:0]  cfg_default_page = PAGE_RST;
  logic [2:0]  cfg_events_page  = EVENTS_PAGE_RST;
  logic        cfg_ack_en       = ACK_ENABLE_RST;

  // display state copy
  logic [2:0]  page_q   = PAGE_RST;
  logic [3:0]  point_q  = 4'd0;
  bit          blank_on = 1'b0;
  logic [31:0] blank_t0 = 32'd0;
  bit          hold_on [5] = '{default: 1'b0};
  logic [31:0] hold_t0 [5] = '{default: 32'd0};
  logic [2:0]  level_q  = 3'd0;

  disp_t display_due_q [$];
  int    errors = 0;
  int    hold_off_cycles = 0;
  int    stall_left = 0;
  bit    calm = 1'b0;

  // stimulus state
  logic [31:0] clock_ms = 32'hFFFF_FF00;
  bit          lvl_brake, lvl_main, lvl_park, lvl_remind;
  logic [15:0] fault_now = 16'd0;
  logic [3:0]  point_sel = 4'd0;
  turn_mode_t  turn_sel = TURN_OFF;

  task automatic report(input string line);
    $display("%0t: %s", $realtime, line);
    errors++;
  endtask

  function automatic void arm_timer(input hold_slot_t k, input logic [31:0] now);
    hold_t0[k] = now;
    hold_on[k] = 1'b1;
  endfunction

  function automatic bit timer_live(input hold_slot_t k, input logic [31:0] now);
    if (hold_on[k] && 32'(now - hold_t0[k]) >= {16'd0, cfg_hold}) hold_on[k] = 1'b0;
    return hold_on[k];
  endfunction

  function automatic msg_code_t event_code(input tick_t t);
    logic [31:0] now;
    now = t.now_ms;
    if (t.braking && !level_q[0]) arm_timer(EV_BRAKE, now);
    if (t.main_light_on && !level_q[1]) arm_timer(EV_MAIN, now);
    if (t.park_light_on && !level_q[2]) arm_timer(EV_PARK, now);
    level_q = {t.park_light_on, t.main_light_on, t.braking};
    if ((t.fault_bits & cfg_mask) != 16'd0) arm_timer(EV_FAULT, now);
    if (cfg_ack_en && t.ack_rose) arm_timer(EV_ACK, now);
    if (timer_live(EV_BRAKE, now)) return CODE_BRAKE;
    else if (timer_live(EV_ACK, now)) return CODE_ACK;
    else if (timer_live(EV_FAULT, now)) return CODE_FAULT;
    else if (timer_live(EV_MAIN, now)) return CODE_MAIN;
    else if (timer_live(EV_PARK, now)) return CODE_PARK;
    else if (t.turn_mode == TURN_HAZARD) return CODE_HAZARD;
    else if (t.turn_mode == TURN_LEFT || t.turn_mode == TURN_RIGHT) begin
      if (t.reminder_active) return CODE_REMINDER;
      return (t.turn_mode == TURN_LEFT) ? CODE_LEFT : CODE_RIGHT;
    end
    return CODE_NONE;
  endfunction

  function automatic disp_t predict_display(input tick_t t);
    disp_t     r;
    bit        dark;
    msg_code_t code;
    dark = 1'b0;
    code = CODE_NONE;
    if (t.page_button_rose) page_q = 3'((page_q + 1) % NUM_PAGES);
    if (t.point_number != point_q) begin
      point_q  = t.point_number;
      blank_on = 1'b1;
      blank_t0 = t.now_ms;
    end
    if (blank_on) begin
      if (32'(t.now_ms - blank_t0) < {16'd0, cfg_blank}) dark = 1'b1;
      else blank_on = 1'b0;
    end
    if (!dark && page_q == cfg_events_page) code = event_code(t);
    r.page_index   = page_q;
    r.blanked      = dark;
    r.message_code = code;
    r.point_digit  = point_q;
    return r;
  endfunction

  function automatic void apply_reg(input cfg_index_t idx, input logic [15:0] val);
    case (idx)
      CFG_EVENT_HOLD:   cfg_hold = val;
      CFG_BLANK:        cfg_blank = val;
      CFG_FAULT_MASK:   cfg_mask = val;
      CFG_DEFAULT_PAGE: cfg_default_page = val[2:0];
      CFG_EVENTS_PAGE:  cfg_events_page = val[2:0];
      CFG_ACK_ENABLE:   cfg_ack_en = val[0];
      default: ;
    endcase
  endfunction

  // leaves valid high so back-to-back ticks need no extra assignment
  task automatic send_tick(input tick_t t);
    tick.valid <= 1'b1;
    tick.data  <= t;
    do @(posedge clk); while (!tick.ready);
    display_due_q.push_back(predict_display(t));
  endtask

  task automatic pause_ticks(input int n);
    tick.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    tick.valid <= 1'b0;
    while (display_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] hold, input logic [15:0] blank,
                          input logic [15:0] mask, input logic [2:0] dpage,
                          input logic [2:0] epage, input logic ack_en);
    cfg_index_t  order [6];
    logic [15:0] vals [6];
    order = '{CFG_EVENT_HOLD, CFG_BLANK, CFG_FAULT_MASK, CFG_DEFAULT_PAGE,
              CFG_EVENTS_PAGE, CFG_ACK_ENABLE};
    vals  = '{hold, blank, mask, {13'd0, dpage}, {13'd0, epage}, {15'd0, ack_en}};
    settle();
    foreach (order[i]) begin
      cfg.valid <= 1'b1;
      cfg.index <= order[i];
      cfg.wdata <= vals[i];
      do @(posedge clk); while (!cfg.ready);
      apply_reg(order[i], vals[i]);
    end
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_ticks(input int count, input int max_step, input bit idle_ok);
    tick_t t;
    repeat (count) begin
      clock_ms = clock_ms + 32'($urandom_range(0, max_step));
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
      if ($urandom_range(0, 11) == 0) point_sel = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) == 0) lvl_brake = ~lvl_brake;
      if ($urandom_range(0, 5) == 0) lvl_main = ~lvl_main;
      if ($urandom_range(0, 5) == 0) lvl_park = ~lvl_park;
      if ($urandom_range(0, 4) == 0) lvl_remind = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) turn_sel = turn_mode_t'($urandom_range(0, 3));
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0: fault_now = 16'd0;
          1: fault_now = 16'(1 << $urandom_range(0, 15));
          default: fault_now = 16'($urandom);
        endcase
      end
      t = '0;
      t.now_ms          = clock_ms;
      t.page_button_rose = (page_q != cfg_events_page) ? ($urandom_range(0, 2) == 0)
                                                        : ($urandom_range(0, 24) == 0);
      t.point_number    = point_sel;
      t.braking         = lvl_brake;
      t.main_light_on   = lvl_main;
      t.park_light_on   = lvl_park;
      t.fault_bits      = fault_now;
      t.ack_rose        = ($urandom_range(0, 9) == 0);
      t.turn_mode       = turn_sel;
      t.reminder_active = lvl_remind;
      send_tick(t);
      if (idle_ok && !calm && $urandom_range(0, 5) == 0) pause_ticks($urandom_range(1, 5));
    end
  endtask

  task automatic test_directed();
    tick_t d;
    logic [31:0] t0;
    t0 = 32'hFFFF_FF00;
    d = '0;
    d.now_ms = t0;                                    send_tick(d);
    d.now_ms = t0 + 1; d.turn_mode = TURN_LEFT;       send_tick(d);
    d.now_ms = t0 + 2; d.turn_mode = TURN_RIGHT;
    d.reminder_active = 1'b1;                         send_tick(d);
    d.now_ms = t0 + 3; d.reminder_active = 1'b0;      send_tick(d);
    d.now_ms = t0 + 4; d.turn_mode = TURN_HAZARD;     send_tick(d);
    // every event at once: brake wins
    d.now_ms = t0 + 5; d.braking = 1'b1; d.main_light_on = 1'b1;
    d.park_light_on = 1'b1; d.ack_rose = 1'b1; d.fault_bits = 16'hFFFF;
    send_tick(d);
    d.now_ms = t0 + 6; d.ack_rose = 1'b0; d.fault_bits = 16'd0;
    send_tick(d);
    // past the hold time and across the timestamp wrap
    d.now_ms = t0 + 1006;                             send_tick(d);
    d.now_ms = t0 + 1007; d.braking = 1'b0; d.fault_bits = 16'h8000;
    send_tick(d);
    d.now_ms = t0 + 1008; d.fault_bits = 16'd0; d.ack_rose = 1'b1;
    send_tick(d);
    d.now_ms = t0 + 1009; d.ack_rose = 1'b0; d.braking = 1'b1;
    send_tick(d);
    d.now_ms = t0 + 1010; d.point_number = 4'd15;     send_tick(d);
    d.now_ms = t0 + 1509; d.braking = 1'b0;           send_tick(d);
    d.now_ms = t0 + 1510; d.braking = 1'b1;           send_tick(d);
    d.page_button_rose = 1'b1;
    repeat (5) begin
      d.now_ms = d.now_ms + 1;
      send_tick(d);
    end
    d.now_ms = 32'hFFFF_FFFF; d.page_button_rose = 1'b0; d.point_number = 4'd0;
    send_tick(d);
    clock_ms = 32'hFFFF_FFF0;
  endtask

  task automatic test_zero_times();
    set_regs(16'd0, 16'd0, 16'hFFFF, 3'd0, 3'd0, 1'b1);
    random_ticks(60, 20, 1'b1);
  endtask

  task automatic test_long_times();
    set_regs(16'hFFFF, 16'hFFFF, 16'h0000, 3'd3, 3'd0, 1'b0);
    random_ticks(50, 9000, 1'b1);
  endtask

  task automatic test_fault_mask();
    set_regs(16'd40, 16'd25, 16'h00F0, 3'd5, 3'd2, 1'b1);
    random_ticks(80, 15, 1'b1);
  endtask

  task automatic test_unreachable_page();
    set_regs(16'd30, 16'd10, 16'h8001, 3'd7, 3'd7, 1'b1);
    random_ticks(30, 10, 1'b1);
  endtask

  task automatic test_last_page();
    set_regs(16'd60, 16'd20, 16'hFFFF, 3'd4, 3'd4, 1'b1);
    random_ticks(60, 20, 1'b1);
  endtask

  task automatic test_hold_off();
    set_regs(16'd200, 16'd30, 16'h0F0F, 3'd0, 3'd0, 1'b1);
    hold_off_cycles = 40;
    random_ticks(12, 10, 1'b0);
  endtask

  task automatic test_steady();
    set_regs(16'd100, 16'd50, 16'hFFFF, 3'd0, 3'd0, 1'b1);
    calm = 1'b1;
    random_ticks(100, 15, 1'b1);
  endtask

  // receiver: long hold-off on request, otherwise random stall bursts (none while calm)
  initial begin
    disp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        disp.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
        disp.ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        disp.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        disp.ready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        disp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    disp_t got, want;
    if (!rst && disp.valid && disp.ready) begin
      got = disp.data;
      if (display_due_q.size() == 0) begin
        report($sformatf("unexpected display transaction %h", got));
      end else begin
        want = display_due_q.pop_front();
        if (got.page_index !== want.page_index)
          report($sformatf("page_index got %0d want %0d", got.page_index, want.page_index));
        if (got.blanked !== want.blanked)
          report($sformatf("blanked got %0d want %0d", got.blanked, want.blanked));
        if (got.message_code !== want.message_code)
          report($sformatf("message_code got %0d want %0d",
                           got.message_code, want.message_code));
        if (got.point_digit !== want.point_digit)
          report($sformatf("point_digit got %0d want %0d", got.point_digit, want.point_digit));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_event_message_priority_display: errors");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    tick.valid <= 1'b0;
    tick.data  <= '0;
    cfg.valid  <= 1'b0;
    cfg.index  <= CFG_EVENT_HOLD;
    cfg.wdata  <= 16'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_zero_times();
    test_long_times();
    test_fault_mask();
    test_unreachable_page();
    test_last_page();
    test_hold_off();
    test_steady();
    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_event_message_priority_display: clean");
    end else begin
      $display("tb_event_message_priority_display: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/emp_pkg.sv
src/emp_tick_if.sv
src/emp_disp_if.sv
src/emp_cfg_if.sv
src/event_message_priority_display.sv
tb/tb_event_message_priority_display.sv
